// File: design/imm_pkg.sv
// Shared types and constants for the int8 16x16x16 matrix multiply-accumulate block.
`timescale 1ns / 1ps

package imm_pkg;

  // Matrix geometry
  localparam int DIM    = 16;
  localparam int LANES  = 64;
  localparam int PACK   = 4;
  localparam int LANE_W = 6;
  localparam int ROW_W  = 2;
  localparam int GRP_W  = 2;
  localparam int WORD_W = 32;

  // Width of a four-term signed byte dot product
  localparam int DOT_W  = 18;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } imm_state_e;

  // One input word
  typedef struct packed {
    logic        [31:0] a_word;
    logic        [31:0] b_word;
    logic signed [31:0] c_row0;
    logic signed [31:0] c_row1;
    logic signed [31:0] c_row2;
    logic signed [31:0] c_row3;
  } imm_in_t;

  // One result word
  typedef struct packed {
    logic        [5:0]  lane;
    logic signed [31:0] d_row0;
    logic signed [31:0] d_row1;
    logic signed [31:0] d_row2;
    logic signed [31:0] d_row3;
    logic               last;
  } imm_out_t;

  // Position of one dot-product step: output lane, row within lane, k group
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [ROW_W-1:0]  row;
    logic [GRP_W-1:0]  grp;
  } imm_tag_t;

  localparam int TAG_W = LANE_W + ROW_W + GRP_W;

endpackage

// File: design/imm_dot4.sv
// Shared four-lane signed byte dot product unit with registered result.
`timescale 1ns / 1ps

module imm_dot4 (
  input  logic                             clk_i,
  input  logic [31:0]                      a_i,
  input  logic [31:0]                      b_i,
  output logic signed [imm_pkg::DOT_W-1:0] dot_o
);
  import imm_pkg::*;

  logic signed [DOT_W-1:0] dot_d;
  logic signed [DOT_W-1:0] dot_q;

  // Multiply each byte pair and sum the four products
  always_comb begin
    logic signed [15:0] prod;
    dot_d = '0;
    for (int i = 0; i < PACK; i++) begin
      prod  = signed'(a_i[8*i +: 8]) * signed'(b_i[8*i +: 8]);
      dot_d = dot_d + DOT_W'(prod);
    end
  end

  // Register the sum
  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
  end

  assign dot_o = dot_q;

endmodule

// File: design/int8_matrix_mac_16x16x16.sv
// Top level of the int8 16x16x16 matrix multiply-accumulate block.
`timescale 1ns / 1ps
//
// Computes D = A*B + C for 16x16 signed byte matrices A, B and a 32-bit C.
// Input: a word is taken at each rising edge with start_i high and busy_o
// low. Sixty-four words (lane 0 first) load A, B and C into three 64-entry
// memories, one word a cycle with no gaps required.
// After the 64th word busy_o rises and the block runs 1024 steps of one
// shared four-byte dot product unit (4 steps per D element, 16 per lane),
// one step a cycle, fed by one read port on each memory.
// Output: each lane's result is on result_o for one cycle with
// result_valid_o high, in lane order, each registered once the last dot
// product step of its lane has been accumulated.
// busy_o falls the cycle the last result appears; a new batch of 64 words
// may start at once. The block takes no new words while a batch runs; its
// pace is set by the single dot product unit.
// The receiver cannot stall: results are never held.
// Reset clears the sequencer and the load count; memory contents stay
// undefined until loaded.

module int8_matrix_mac_16x16x16 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  imm_pkg::imm_in_t  item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output imm_pkg::imm_out_t result_o
);
  import imm_pkg::*;

  // Sequencer
  imm_state_e state_q, state_d;
  logic       load_fire;
  logic       issue;
  logic       final_step;

  logic [LANE_W-1:0] load_cnt_q;
  imm_tag_t          idx_q;
  imm_tag_t          t1_q, t2_q;
  logic              v1_q, v2_q;

  // Memories and read data
  logic [WORD_W-1:0]           a_mem [LANES];
  logic [WORD_W-1:0]           b_mem [LANES];
  logic [PACK-1:0][WORD_W-1:0] c_mem [LANES];

  logic [LANE_W-1:0]           a_addr, b_addr, c_addr;
  logic [WORD_W-1:0]           a_rd_q, b_rd_q;
  logic [PACK-1:0][WORD_W-1:0] c_rd_q;

  // Accumulation
  logic signed [DOT_W-1:0]     dot;
  logic [WORD_W-1:0]           dot_ext;
  logic [WORD_W-1:0]           c2_q;
  logic [WORD_W-1:0]           acc_q;
  logic [WORD_W-1:0]           acc_sum;
  logic [PACK-1:0][WORD_W-1:0] d_q;
  logic                        lane_done;

  imm_out_t result_q;
  logic     result_valid_q;

  assign busy_o     = (state_q != ST_LOAD);
  assign load_fire  = start_i && !busy_o;
  assign final_step = v2_q && (t2_q == '1);

  // Next state and issue control
  always_comb begin
    state_d = state_q;
    issue   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (load_fire && (load_cnt_q == '1)) state_d = ST_RUN;
      end
      ST_RUN: begin
        issue = 1'b1;
        if (idx_q == '1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (final_step) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Hold state, load count, step index and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      idx_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_fire) load_cnt_q <= load_cnt_q + LANE_W'(1);
      if (issue) idx_q <= imm_tag_t'(idx_q + TAG_W'(1));
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // Advance step tags alongside the data
  always_ff @(posedge clk_i) begin
    t1_q <= idx_q;
    t2_q <= t1_q;
  end

  // A row of a lane's k group is one A word; its column is one B word
  assign a_addr = {idx_q.grp, idx_q.lane[5:4], idx_q.row};
  assign b_addr = {idx_q.grp, idx_q.lane[3:0]};
  assign c_addr = idx_q.lane;

  // Write loaded words, read operands with registered output
  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      a_mem[load_cnt_q] <= item_i.a_word;
      b_mem[load_cnt_q] <= item_i.b_word;
      c_mem[load_cnt_q] <= {item_i.c_row3, item_i.c_row2, item_i.c_row1, item_i.c_row0};
    end
    a_rd_q <= a_mem[a_addr];
    b_rd_q <= b_mem[b_addr];
    c_rd_q <= c_mem[c_addr];
  end

  imm_dot4 u_dot4 (
    .clk_i (clk_i),
    .a_i   (a_rd_q),
    .b_i   (b_rd_q),
    .dot_o (dot)
  );

  // Pick the C word for this row, in step with the dot product
  always_ff @(posedge clk_i) begin
    c2_q <= c_rd_q[t1_q.row];
  end

  assign dot_ext   = {{(WORD_W-DOT_W){dot[DOT_W-1]}}, dot};
  assign acc_sum   = ((t2_q.grp == '0) ? c2_q : acc_q) + dot_ext;
  assign lane_done = v2_q && (t2_q.grp == '1) && (t2_q.row == '1);

  // Accumulate and keep finished rows of the current lane
  always_ff @(posedge clk_i) begin
    if (v2_q) acc_q <= acc_sum;
    if (v2_q && (t2_q.grp == '1)) d_q[t2_q.row] <= acc_sum;
    if (lane_done) begin
      result_q.lane   <= t2_q.lane;
      result_q.d_row0 <= d_q[0];
      result_q.d_row1 <= d_q[1];
      result_q.d_row2 <= d_q[2];
      result_q.d_row3 <= acc_sum;
      result_q.last   <= (t2_q.lane == '1);
    end
  end

  // Strobe each result word for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= lane_done;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
